/* rtl/tone_sequence_player_defines.svh */
// ----------------------------------------------------------------------------
// Tone sequence player: assertion macros
// Shared property forms for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef TONE_SEQUENCE_PLAYER_DEFINES_SVH
`define TONE_SEQUENCE_PLAYER_DEFINES_SVH

// same-cycle implication, off during reset
`define TSP_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define TSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tsp_pkg.sv */
// ----------------------------------------------------------------------------
// Tone sequence player package
// Codes, word types and the tone sequence ROM.
// ----------------------------------------------------------------------------
`default_nettype none

package tsp_pkg;

    localparam int QUEUE_DEPTH_DEF    = 5;
    localparam int SEQUENCE_COUNT_DEF = 9;
    localparam int MAX_STEPS_DEF      = 11;

    localparam int ROM_SEQS  = 9;
    localparam int ROM_STEPS = 11;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_VOLUME       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_FREQ = 2'd1;

    localparam logic [15:0] DEFAULT_FREQ_RESET = 16'd1000;
    localparam logic [2:0]  PENDING_MAX        = 3'd7;

    localparam logic [3:0] BEEP_STEP_FREQ  = 4'd0;
    localparam logic [3:0] BEEP_STEP_START = 4'd1;
    localparam logic [3:0] BEEP_STEP_DELAY = 4'd2;
    localparam logic [3:0] BEEP_STEP_STOP  = 4'd3;

    typedef enum logic [1:0] {
        KIND_TICK   = 2'd0,
        KIND_BEEP   = 2'd1,
        KIND_SEQ    = 2'd2,
        KIND_ENABLE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        OP_END   = 3'd0,
        OP_FREQ  = 3'd1,
        OP_START = 3'd2,
        OP_STOP  = 3'd3,
        OP_DELAY = 3'd4
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [15:0] arg;
    } t_step;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] freq;
        logic [15:0] dur;
        logic [3:0]  seq;
        logic        en;
    } t_request;

    typedef struct packed {
        logic push;
        logic flush;
        logic pop;
    } t_q_cmd;

    typedef struct packed {
        logic        tone_on;
        logic [15:0] tone_frequency;
        logic [1:0]  gain_level;
        logic        busy_res;
        logic        request_done;
        logic        refused;
        logic [2:0]  pending_count;
    } t_result;

    localparam t_step STEP_END = '{op: OP_END, arg: 16'd0};

    localparam t_step ROM_TABLE [ROM_SEQS][ROM_STEPS] = '{
        '{'{OP_FREQ, 16'd2000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd25},
          '{OP_FREQ, 16'd1500}, '{OP_DELAY, 16'd25}, '{OP_FREQ, 16'd1250},
          '{OP_DELAY, 16'd25}, '{OP_FREQ, 16'd1000}, '{OP_DELAY, 16'd25},
          '{OP_STOP, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1500}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd25},
          '{OP_FREQ, 16'd1000}, '{OP_DELAY, 16'd25}, '{OP_FREQ, 16'd750},
          '{OP_DELAY, 16'd50}, '{OP_FREQ, 16'd500}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_FREQ, 16'd1500},
          '{OP_START, 16'd0}, '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd750}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_FREQ, 16'd1000},
          '{OP_START, 16'd0}, '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd2000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_START, 16'd0},
          '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd500}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd100},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_START, 16'd0},
          '{OP_DELAY, 16'd100}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd100},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_START, 16'd0},
          '{OP_DELAY, 16'd100}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_FREQ, 16'd2000}, '{OP_DELAY, 16'd50}, '{OP_FREQ, 16'd1500},
          '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd120},
          '{OP_FREQ, 16'd2000}, '{OP_DELAY, 16'd120}, '{OP_FREQ, 16'd1500},
          '{OP_DELAY, 16'd120}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}}
    };

    function automatic t_step rom_step(input logic [3:0] seq, input logic [3:0] idx);
        t_step s;
        s = STEP_END;
        if (seq < 4'(ROM_SEQS) && idx < 4'(ROM_STEPS)) begin
            s = ROM_TABLE[seq][idx];
        end
        return s;
    endfunction

endpackage

`default_nettype wire

/* rtl/tsp_req_if.sv */
// ----------------------------------------------------------------------------
// Tone sequence player request channel
// Valid/ready channel carrying one tick or request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsp_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [15:0] beep_frequency;
    logic [15:0] beep_duration;
    logic [3:0]  sequence_id;
    logic        enable_value;

    modport source (
        output valid, cmd, beep_frequency, beep_duration, sequence_id, enable_value,
        input  ready
    );

    modport sink (
        input  valid, cmd, beep_frequency, beep_duration, sequence_id, enable_value,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/tsp_res_if.sv */
// ----------------------------------------------------------------------------
// Tone sequence player result channel
// Valid/ready channel carrying one status word per tick or request word.
// ----------------------------------------------------------------------------
`default_nettype none

interface tsp_res_if;
    logic        valid;
    logic        ready;
    logic        tone_on;
    logic [15:0] tone_frequency;
    logic [1:0]  gain_level;
    logic        busy_res;
    logic        request_done;
    logic        refused;
    logic [2:0]  pending_count;

    modport source (
        output valid, tone_on, tone_frequency, gain_level, busy_res, request_done,
               refused, pending_count,
        input  ready
    );

    modport sink (
        input  valid, tone_on, tone_frequency, gain_level, busy_res, request_done,
               refused, pending_count,
        output ready
    );
endinterface

`default_nettype wire

/* rtl/tsp_queue.sv */
// ----------------------------------------------------------------------------
// Tone sequence player request queue
// Circular request store with flush-and-push, push and pop; registered head read.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_queue import tsp_pkg::*; #(
    parameter  int DEPTH = QUEUE_DEPTH_DEF,
    localparam int HW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int FW    = $clog2(DEPTH + 1)
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire t_q_cmd   i_cmd,
    input  wire t_request i_word,
    output t_request      o_head,
    output logic [FW-1:0] o_fill
);

    t_request        r_mem [DEPTH];
    t_request        r_head_word;
    logic [HW-1:0]   r_head;
    logic [FW-1:0]   r_fill;
    logic [HW-1:0]   n_head;
    logic [HW-1:0]   wr_addr;
    logic [FW:0]     wr_sum;

    always_comb begin
        wr_sum = (FW+1)'(r_head) + (FW+1)'(r_fill);
        if (wr_sum >= (FW+1)'(DEPTH)) begin
            wr_sum = wr_sum - (FW+1)'(DEPTH);
        end
        wr_addr = HW'(wr_sum);
        n_head  = (r_head == HW'(DEPTH - 1)) ? '0 : r_head + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.flush) begin
            r_mem[r_head] <= i_word;
        end else if (i_cmd.push) begin
            r_mem[wr_addr] <= i_word;
        end
        r_head_word <= r_mem[r_head];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_fill <= '0;
        end else if (i_cmd.flush) begin
            r_fill <= FW'(1);
        end else if (i_cmd.push) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_cmd.pop) begin
            r_head <= n_head;
            r_fill <= r_fill - 1'b1;
        end
    end

    assign o_head = r_head_word;
    assign o_fill = r_fill;

endmodule

`default_nettype wire

/* rtl/tsp_step_fetch.sv */
// ----------------------------------------------------------------------------
// Tone sequence player step fetch
// Decodes the step at an index of the running beep or ROM sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module tsp_step_fetch import tsp_pkg::*; #(
    parameter  int SEQUENCE_COUNT = SEQUENCE_COUNT_DEF,
    parameter  int MAX_STEPS      = MAX_STEPS_DEF,
    localparam int SW             = $clog2(MAX_STEPS + 1)
) (
    input  wire t_request  i_request,
    input  wire [SW-1:0]   i_index,
    output t_step          o_step
);

    logic [3:0] idx;

    always_comb begin
        idx    = 4'(i_index);
        o_step = STEP_END;
        if (i_index < SW'(MAX_STEPS)) begin
            if (i_request.kind == KIND_BEEP) begin
                case (idx)
                    BEEP_STEP_FREQ:  o_step = '{op: OP_FREQ,  arg: i_request.freq};
                    BEEP_STEP_START: o_step = '{op: OP_START, arg: 16'd0};
                    BEEP_STEP_DELAY: o_step = '{op: OP_DELAY, arg: i_request.dur};
                    BEEP_STEP_STOP:  o_step = '{op: OP_STOP,  arg: 16'd0};
                    default:         o_step = STEP_END;
                endcase
            end else if ({1'b0, i_request.seq} < 5'(SEQUENCE_COUNT)) begin
                o_step = rom_step(i_request.seq, idx);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/tone_sequence_player.sv */
// ----------------------------------------------------------------------------
// Tone sequence player
// Buzzer controller: queues beep, sequence and enable requests and walks
// the tone steps on 1 ms ticks.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries a tick or a request word; o_res returns one status word for
//   each, in order. Registers are to be written through i_cfg_* while idle;
//   the block itself does not enforce this. A request word goes from S_IDLE
//   to S_DONE, which registers its status word. A tick that only counts a
//   delay down goes to S_DONE; else S_TAKE takes the queue head if none plays,
//   and S_WALK walks each step, the end step included, before S_DONE.
//   i_req.ready is high only while the sequencer is idle; one word is worked
//   at a time, and the next is taken the cycle after the status is registered.
//   A stalled o_res holds its word; the sequencer then waits with its status
//   until the output register frees.
//   Reset empties the queue, stops the tone, enables playback and sets the
//   frequency to 1000 Hz and the gain to 0.
// ----------------------------------------------------------------------------
`default_nettype none

`include "tone_sequence_player_defines.svh"

module tone_sequence_player import tsp_pkg::*; #(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int SEQUENCE_COUNT = SEQUENCE_COUNT_DEF,
    parameter int MAX_STEPS      = MAX_STEPS_DEF
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    tsp_req_if.sink               i_req,
    tsp_res_if.source             o_res,
    input  wire                   i_cfg_we,
    input  wire [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire [CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = $clog2(MAX_STEPS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_TAKE,
        S_WALK,
        S_DONE
    } t_state;

    t_state        r_state;
    t_request      r_cur;
    logic          r_playing;
    logic          r_drive;
    logic          r_enabled;
    logic          r_done;
    logic          r_refused;
    logic [SW-1:0] r_step;
    logic [15:0]   r_delay;
    logic [15:0]   r_freq_now;
    logic [15:0]   r_freq_saved;
    logic [1:0]    r_volume;
    logic          r_out_valid;
    t_result       r_res;

    t_request      req_word;
    t_request      q_head;
    t_q_cmd        q_cmd;
    logic [FW-1:0] q_fill;
    logic [4:0]    fill_ext;
    t_step         step;
    logic          req_acc;
    logic          seq_bad;
    logic          play_ok;
    logic [15:0]   delay_dec;

    tsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (q_cmd),
        .i_word  (req_word),
        .o_head  (q_head),
        .o_fill  (q_fill)
    );

    tsp_step_fetch #(
        .SEQUENCE_COUNT (SEQUENCE_COUNT),
        .MAX_STEPS      (MAX_STEPS)
    ) u_fetch (
        .i_request (r_cur),
        .i_index   (r_step),
        .o_step    (step)
    );

    assign i_req.ready = (r_state == S_IDLE);
    assign req_acc     = i_req.valid && i_req.ready;

    always_comb begin
        req_word  = '{kind: t_kind'(i_req.cmd), freq: i_req.beep_frequency,
                      dur: i_req.beep_duration, seq: i_req.sequence_id,
                      en: i_req.enable_value};
        seq_bad   = (t_kind'(i_req.cmd) == KIND_SEQ) &&
                    ({1'b0, i_req.sequence_id} >= 5'(SEQUENCE_COUNT));
        play_ok   = r_enabled && (q_fill < FW'(QUEUE_DEPTH));
        delay_dec = r_delay - 16'd1;
        fill_ext  = 5'(q_fill);
        q_cmd     = '0;
        if (req_acc) begin
            unique case (t_kind'(i_req.cmd)) inside
                KIND_TICK:           q_cmd.push  = 1'b0;
                KIND_ENABLE:         q_cmd.flush = 1'b1;
                KIND_BEEP, KIND_SEQ: q_cmd.push  = !seq_bad && play_ok;
            endcase
        end
        if (r_state == S_TAKE) begin
            q_cmd.pop = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_cur        <= '0;
            r_playing    <= 1'b0;
            r_drive      <= 1'b0;
            r_enabled    <= 1'b1;
            r_done       <= 1'b0;
            r_refused    <= 1'b0;
            r_step       <= '0;
            r_delay      <= '0;
            r_freq_now   <= DEFAULT_FREQ_RESET;
            r_freq_saved <= '0;
            r_volume     <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (o_res.ready && r_state != S_DONE) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_VOLUME: r_volume <= i_cfg_data[1:0];
                    CFG_DEFAULT_FREQ: begin
                        if (r_playing) begin
                            r_freq_saved <= i_cfg_data;
                        end else begin
                            r_freq_now <= i_cfg_data;
                        end
                    end
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (req_acc) begin
                        r_done    <= 1'b0;
                        r_refused <= 1'b0;
                        r_state   <= S_DONE;
                        unique case (t_kind'(i_req.cmd)) inside
                            KIND_TICK: begin
                                if (r_playing && r_delay != 16'd0) begin
                                    r_delay <= delay_dec;
                                    if (delay_dec == 16'd0) begin
                                        r_state <= S_WALK;
                                    end
                                end else if (!r_playing && q_fill != '0) begin
                                    r_state <= S_TAKE;
                                end else if (r_playing) begin
                                    r_state <= S_WALK;
                                end
                            end
                            KIND_BEEP, KIND_SEQ: r_refused <= !seq_bad && !play_ok;
                            KIND_ENABLE:         r_refused <= 1'b0;
                        endcase
                    end
                end
                S_TAKE: begin
                    if (q_head.kind == KIND_ENABLE) begin
                        r_enabled <= q_head.en;
                        r_drive   <= 1'b0;
                        r_done    <= 1'b1;
                        r_state   <= S_DONE;
                    end else begin
                        r_cur        <= q_head;
                        r_playing    <= 1'b1;
                        r_step       <= '0;
                        r_delay      <= '0;
                        r_freq_saved <= r_freq_now;
                        r_state      <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (step.op == OP_END) begin
                        r_freq_now <= r_freq_saved;
                        r_playing  <= 1'b0;
                        r_done     <= 1'b1;
                        r_state    <= S_DONE;
                    end else begin
                        r_step <= r_step + 1'b1;
                        unique case (step.op)
                            OP_FREQ:  r_freq_now <= step.arg;
                            OP_START: r_drive    <= 1'b1;
                            OP_STOP:  r_drive    <= 1'b0;
                            OP_DELAY: begin
                                if (step.arg != 16'd0) begin
                                    r_delay <= step.arg;
                                    r_state <= S_DONE;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid <= 1'b1;
                        r_res       <= '{tone_on: r_drive,
                                         tone_frequency: r_freq_now,
                                         gain_level: r_volume,
                                         busy_res: r_playing || (q_fill != '0),
                                         request_done: r_done,
                                         refused: r_refused,
                                         pending_count: (fill_ext > 5'(PENDING_MAX)) ?
                                                        PENDING_MAX : fill_ext[2:0]};
                        r_state     <= S_IDLE;
                    end
                end
            endcase
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.tone_on        = r_res.tone_on;
    assign o_res.tone_frequency = r_res.tone_frequency;
    assign o_res.gain_level     = r_res.gain_level;
    assign o_res.busy_res       = r_res.busy_res;
    assign o_res.request_done   = r_res.request_done;
    assign o_res.refused        = r_res.refused;
    assign o_res.pending_count  = r_res.pending_count;

    `TSP_ASSERT_IMPLY(a_fill_bound, i_clk, i_rst_n, 1'b1,
        q_fill <= FW'(QUEUE_DEPTH), "request queue overfilled")
    `TSP_ASSERT_IMPLY(a_step_bound, i_clk, i_rst_n, r_state == S_WALK,
        r_step <= SW'(MAX_STEPS) && r_playing, "step walk out of range")
    `TSP_ASSERT_NEXT(a_end_stops, i_clk, i_rst_n, r_state == S_WALK && step.op == OP_END,
        !r_playing && r_state == S_DONE, "end step left playback running")
    `TSP_ASSERT_IMPLY(a_done_refused, i_clk, i_rst_n, o_res.valid,
        !(o_res.request_done && o_res.refused), "word both finished and refused")

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// Tone sequence player regression bench
// Sends tick, beep, sequence and enable words through the request channel,
// predicts every status word with a cycle-free model of the player and checks
// each returned word field by field. Registers are changed between phases,
// while no status word is outstanding. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tsp_pkg::*;

    localparam int FIFO_DEPTH   = 5;
    localparam int SEQ_COUNT    = 9;
    localparam int STEP_LIMIT   = 11;
    localparam int SETTLE_CYCLES = 24;
    localparam int CYCLE_LIMIT  = 400000;

    localparam logic [15:0] RESET_FREQ = 16'd1000;
    localparam logic [1:0]  CFG_SPARE_A = 2'd2;
    localparam logic [1:0]  CFG_SPARE_B = 2'd3;

    localparam t_step TONE_STEPS [SEQ_COUNT][STEP_LIMIT] = '{
        '{'{OP_FREQ, 16'd2000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd25},
          '{OP_FREQ, 16'd1500}, '{OP_DELAY, 16'd25}, '{OP_FREQ, 16'd1250},
          '{OP_DELAY, 16'd25}, '{OP_FREQ, 16'd1000}, '{OP_DELAY, 16'd25},
          '{OP_STOP, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1500}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd25},
          '{OP_FREQ, 16'd1000}, '{OP_DELAY, 16'd25}, '{OP_FREQ, 16'd750},
          '{OP_DELAY, 16'd50}, '{OP_FREQ, 16'd500}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_FREQ, 16'd1500},
          '{OP_START, 16'd0}, '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd750}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_FREQ, 16'd1000},
          '{OP_START, 16'd0}, '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd2000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_START, 16'd0},
          '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd500}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd100},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_START, 16'd0},
          '{OP_DELAY, 16'd100}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd100},
          '{OP_STOP, 16'd0}, '{OP_DELAY, 16'd100}, '{OP_START, 16'd0},
          '{OP_DELAY, 16'd100}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd50},
          '{OP_FREQ, 16'd2000}, '{OP_DELAY, 16'd50}, '{OP_FREQ, 16'd1500},
          '{OP_DELAY, 16'd50}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}},
        '{'{OP_FREQ, 16'd1000}, '{OP_START, 16'd0}, '{OP_DELAY, 16'd120},
          '{OP_FREQ, 16'd2000}, '{OP_DELAY, 16'd120}, '{OP_FREQ, 16'd1500},
          '{OP_DELAY, 16'd120}, '{OP_STOP, 16'd0}, '{OP_END, 16'd0},
          '{OP_END, 16'd0}, '{OP_END, 16'd0}}
    };

    logic i_clk;
    logic i_rst_n;
    logic cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    tsp_req_if req_ch ();
    tsp_res_if res_ch ();

    tone_sequence_player dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_ch),
        .o_res       (res_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // player model state
    t_request    fifo_words [FIFO_DEPTH];
    int unsigned fifo_head    = 0;
    int unsigned fifo_fill    = 0;
    t_request    active_req   = '0;
    bit          is_playing   = 1'b0;
    int unsigned step_pos     = 0;
    logic [15:0] ms_left      = 16'd0;
    logic [15:0] freq_live    = RESET_FREQ;
    logic [15:0] freq_restore = 16'd0;
    bit          buzzer_on    = 1'b0;
    bit          play_enable  = 1'b1;
    logic [1:0]  gain_reg     = 2'd0;

    t_request    send_words [$];
    t_result     status_due [$];
    bit          word_taken   = 1'b0;
    int unsigned error_count  = 0;
    int unsigned cycle_count  = 0;
    int unsigned burst_left   = 1;
    int unsigned gap_left     = 0;
    int unsigned ready_run    = 0;
    bit          ready_mode   = 1'b0;

    function automatic t_step next_step(input t_request rq, input int unsigned idx);
        t_step s;
        s = '{OP_END, 16'd0};
        if (idx < STEP_LIMIT) begin
            if (rq.kind == KIND_BEEP) begin
                case (idx)
                    BEEP_STEP_FREQ:  s = '{OP_FREQ, rq.freq};
                    BEEP_STEP_START: s = '{OP_START, 16'd0};
                    BEEP_STEP_DELAY: s = '{OP_DELAY, rq.dur};
                    BEEP_STEP_STOP:  s = '{OP_STOP, 16'd0};
                    default: ;
                endcase
            end else if (rq.seq < SEQ_COUNT) begin
                s = TONE_STEPS[rq.seq][idx];
            end
        end
        return s;
    endfunction

    // walk zero-time steps; true when the request has ended
    function automatic bit play_steps();
        t_step s;
        bit    fin;
        bit    paused;
        fin    = 1'b0;
        paused = 1'b0;
        while (!fin && !paused) begin
            s = next_step(active_req, step_pos);
            if (s.op == OP_END) begin
                freq_live  = freq_restore;
                is_playing = 1'b0;
                fin        = 1'b1;
            end else begin
                step_pos++;
                case (s.op)
                    OP_FREQ:  freq_live = s.arg;
                    OP_START: buzzer_on = 1'b1;
                    OP_STOP:  buzzer_on = 1'b0;
                    OP_DELAY: begin
                        if (s.arg != 16'd0) begin
                            ms_left = s.arg;
                            paused  = 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
        return fin;
    endfunction

    function automatic t_result predict_status(input t_request w);
        t_result  r;
        t_request head;
        bit       done;
        bit       refused;
        bit       waiting;
        done    = 1'b0;
        refused = 1'b0;
        waiting = 1'b0;
        case (w.kind)
            KIND_TICK: begin
                if (is_playing && ms_left != 16'd0) begin
                    ms_left--;
                    waiting = (ms_left != 16'd0);
                end
                if (!waiting) begin
                    if (!is_playing && fifo_fill > 0) begin
                        head      = fifo_words[fifo_head];
                        fifo_head = (fifo_head + 1) % FIFO_DEPTH;
                        fifo_fill--;
                        if (head.kind == KIND_ENABLE) begin
                            play_enable = head.en;
                            buzzer_on   = 1'b0;
                            done        = 1'b1;
                        end else begin
                            active_req   = head;
                            is_playing   = 1'b1;
                            step_pos     = 0;
                            ms_left      = 16'd0;
                            freq_restore = freq_live;
                        end
                    end
                    if (is_playing && ms_left == 16'd0) done = play_steps();
                end
            end
            KIND_ENABLE: begin
                fifo_fill = 0;
                fifo_words[fifo_head] = w;
                fifo_fill = 1;
            end
            default: begin
                if (w.kind == KIND_SEQ && w.seq >= SEQ_COUNT) begin
                    // unknown sequence: dropped silently
                end else if (!play_enable || fifo_fill >= FIFO_DEPTH) begin
                    refused = 1'b1;
                end else begin
                    fifo_words[(fifo_head + fifo_fill) % FIFO_DEPTH] = w;
                    fifo_fill++;
                end
            end
        endcase
        r.tone_on        = buzzer_on;
        r.tone_frequency = freq_live;
        r.gain_level     = gain_reg;
        r.busy_res       = is_playing || fifo_fill > 0;
        r.request_done   = done;
        r.refused        = refused;
        r.pending_count  = (fifo_fill > 7) ? 3'd7 : 3'(fifo_fill);
        return r;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned got_val);
        if (exp_val != got_val) begin
            error_count++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_val, got_val);
        end
    endfunction

    function automatic void queue_word(input t_kind kind, input logic [15:0] freq,
                                       input logic [15:0] dur, input logic [3:0] seq,
                                       input logic en);
        send_words.push_back('{kind, freq, dur, seq, en});
    endfunction

    function automatic t_request random_word(input t_kind kind);
        t_request w;
        w.kind = kind;
        w.freq = 16'($urandom_range(0, 16'hFFFF));
        w.dur  = 16'($urandom_range(0, 16'hFFFF));
        w.seq  = 4'($urandom_range(0, 15));
        w.en   = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // a handful of requests, then a run of ticks to play them out
    function automatic void add_episode();
        t_request    w;
        int unsigned pick;
        repeat ($urandom_range(1, 7)) begin
            w    = random_word(KIND_BEEP);
            pick = $urandom_range(0, 39);
            if (pick < 2) begin
                w.kind = KIND_SEQ;
                w.seq  = 4'($urandom_range(0, SEQ_COUNT - 1));
            end else if (pick < 4) begin
                w.kind = KIND_SEQ;
            end else if (pick < 8) begin
                w.kind = KIND_ENABLE;
                w.en   = ($urandom_range(0, 3) != 0);
            end else if (pick == 8) begin
                w.dur = 16'($urandom_range(13, 200));
            end else begin
                w.dur = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(1, 12));
            end
            send_words.push_back(w);
            repeat ($urandom_range(0, 2) == 0 ? $urandom_range(1, 4) : 0)
                send_words.push_back(random_word(KIND_TICK));
        end
        repeat ($urandom_range(0, 9) == 0 ? $urandom_range(150, 400) : $urandom_range(2, 60))
            send_words.push_back(random_word(KIND_TICK));
    endfunction

    function automatic void add_random(input int unsigned count);
        int unsigned start_size;
        start_size = send_words.size();
        while (send_words.size() - start_size < count) add_episode();
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge i_clk);
        while (send_words.size() != 0 || req_ch.valid || status_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // request driver: bursts with random gaps, hold until taken
    always @(negedge i_clk) begin
        t_request w;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || word_taken) begin
            if (gap_left != 0) begin
                gap_left--;
                req_ch.valid <= 1'b0;
            end else if (send_words.size() != 0) begin
                w = send_words.pop_front();
                req_ch.cmd            <= w.kind;
                req_ch.beep_frequency <= w.freq;
                req_ch.beep_duration  <= w.dur;
                req_ch.sequence_id    <= w.seq;
                req_ch.enable_value   <= w.en;
                req_ch.valid          <= 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                end else begin
                    burst_left--;
                end
            end else begin
                req_ch.valid <= 1'b0;
            end
        end
    end

    // status receiver: alternate ready and stall runs
    always @(negedge i_clk) begin
        if (ready_run == 0) begin
            ready_mode = !ready_mode;
            ready_run  = ready_mode ? $urandom_range(1, 30) : $urandom_range(1, 8);
        end
        ready_run--;
        res_ch.ready <= ready_mode;
    end

    always @(posedge i_clk) begin
        t_result  got;
        t_result  exp_word;
        t_request seen;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tone_sequence_player regression: fail");
            $finish;
        end else if (!i_rst_n) begin
            word_taken = 1'b0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                got = {res_ch.tone_on, res_ch.tone_frequency, res_ch.gain_level,
                       res_ch.busy_res, res_ch.request_done, res_ch.refused,
                       res_ch.pending_count};
                if (status_due.size() == 0) begin
                    error_count++;
                    $display("%0t: status word %0h with none expected", $time, got);
                end else begin
                    exp_word = status_due.pop_front();
                    check_field("tone_on", exp_word.tone_on, got.tone_on);
                    check_field("tone_frequency", exp_word.tone_frequency, got.tone_frequency);
                    check_field("gain_level", exp_word.gain_level, got.gain_level);
                    check_field("busy_res", exp_word.busy_res, got.busy_res);
                    check_field("request_done", exp_word.request_done, got.request_done);
                    check_field("refused", exp_word.refused, got.refused);
                    check_field("pending_count", exp_word.pending_count, got.pending_count);
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    CFG_VOLUME: gain_reg = cfg_data[1:0];
                    CFG_DEFAULT_FREQ: begin
                        if (is_playing) freq_restore = cfg_data;
                        else freq_live = cfg_data;
                    end
                    default: ;
                endcase
            end
            word_taken = req_ch.valid && req_ch.ready;
            if (word_taken) begin
                seen = {req_ch.cmd, req_ch.beep_frequency, req_ch.beep_duration,
                        req_ch.sequence_id, req_ch.enable_value};
                status_due.push_back(predict_status(seen));
            end
        end
    end

    initial begin
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = CFG_VOLUME;
        cfg_data              = 16'd0;
        req_ch.valid          = 1'b0;
        req_ch.cmd            = KIND_TICK;
        req_ch.beep_frequency = 16'd0;
        req_ch.beep_duration  = 16'd0;
        req_ch.sequence_id    = 4'd0;
        req_ch.enable_value   = 1'b0;
        res_ch.ready          = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_reg(CFG_VOLUME, 16'hFFFF);
        write_reg(CFG_DEFAULT_FREQ, 16'hFFFF);

        // zero-length beep, then a one-millisecond beep
        queue_word(KIND_BEEP, 16'hFFFF, 16'h0000, 4'h0, 1'b0);
        queue_word(KIND_TICK, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1);
        queue_word(KIND_BEEP, 16'h0000, 16'h0001, 4'hF, 1'b1);
        queue_word(KIND_TICK, 16'h0000, 16'h0000, 4'h0, 1'b0);
        queue_word(KIND_TICK, 16'h5555, 16'hAAAA, 4'h5, 1'b0);
        // unknown sequence ids
        queue_word(KIND_SEQ, 16'h0000, 16'h0000, 4'hF, 1'b0);
        queue_word(KIND_SEQ, 16'hFFFF, 16'hFFFF, 4'h9, 1'b1);
        // fill the queue, then overflow it
        queue_word(KIND_BEEP, 16'hAAAA, 16'h5555, 4'h0, 1'b0);
        queue_word(KIND_BEEP, 16'h5555, 16'hAAAA, 4'hA, 1'b1);
        queue_word(KIND_BEEP, 16'h8000, 16'h7FFF, 4'h5, 1'b0);
        queue_word(KIND_BEEP, 16'h7FFF, 16'h8000, 4'h0, 1'b1);
        queue_word(KIND_SEQ, 16'h1234, 16'h4321, 4'h3, 1'b0);
        queue_word(KIND_BEEP, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1);
        queue_word(KIND_SEQ, 16'h0000, 16'h0000, 4'h0, 1'b0);
        // disable flushes the queue and takes effect on the next tick
        queue_word(KIND_ENABLE, 16'hFFFF, 16'hFFFF, 4'hF, 1'b0);
        queue_word(KIND_TICK, 16'h0000, 16'h0000, 4'h0, 1'b0);
        queue_word(KIND_BEEP, 16'h0001, 16'h8000, 4'h0, 1'b0);
        queue_word(KIND_SEQ, 16'h0000, 16'h0000, 4'h8, 1'b0);
        queue_word(KIND_ENABLE, 16'h0000, 16'h0000, 4'h0, 1'b1);
        queue_word(KIND_TICK, 16'h0000, 16'h0000, 4'h0, 1'b0);
        // start a ROM sequence
        queue_word(KIND_SEQ, 16'h0000, 16'h0000, 4'h0, 1'b0);
        queue_word(KIND_TICK, 16'h0000, 16'h0000, 4'h0, 1'b0);
        queue_word(KIND_TICK, 16'h0000, 16'h0000, 4'h0, 1'b0);
        wait_idle();

        write_reg(CFG_DEFAULT_FREQ, 16'h0000);
        write_reg(CFG_VOLUME, 16'h0000);
        write_reg(CFG_SPARE_A, 16'h1234);
        write_reg(CFG_SPARE_B, 16'hFFFF);
        add_random(350);
        wait_idle();

        write_reg(CFG_VOLUME, 16'hFFFD);
        write_reg(CFG_DEFAULT_FREQ, 16'($urandom_range(0, 16'hFFFF)));
        add_random(350);
        wait_idle();

        write_reg(CFG_VOLUME, 16'h0002);
        write_reg(CFG_DEFAULT_FREQ, RESET_FREQ);
        add_random(350);
        wait_idle();

        if (error_count == 0 && status_due.size() == 0) begin
            $display("tone_sequence_player regression: pass");
        end else begin
            $display("tone_sequence_player regression: fail");
        end
        $finish;
    end
endmodule

/* tone_sequence_player.f */
+incdir+rtl
rtl/tsp_pkg.sv
rtl/tsp_req_if.sv
rtl/tsp_res_if.sv
rtl/tsp_queue.sv
rtl/tsp_step_fetch.sv
rtl/tone_sequence_player.sv
bench/tb.sv
